// ----- rtl/core/smf_pkg.sv -----
// shared constants and types of the sliding median filter
`timescale 1ns / 1ps

package smf_pkg;

	localparam int MAX_HALF_DEF    = 7;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int HALF_BITS       = 3;

	localparam logic [HALF_BITS-1:0] HALF_RESET = 3'd1;

	typedef struct packed {
		logic shift_en;
		logic rank_clr;
		logic rank_en;
	} smf_ctrl_t;

endpackage

// ----- rtl/core/smf_ifs.sv -----
// valid/ready channel interfaces of the sliding median filter
`timescale 1ns / 1ps

interface smf_in_if import smf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          end_of_stream;

	modport source (output valid, sample_in, end_of_stream, input ready);
	modport sink   (input valid, sample_in, end_of_stream, output ready);
endinterface

interface smf_out_if import smf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered_sample;
	logic                          last_out;

	modport source (output valid, filtered_sample, last_out, input ready);
	modport sink   (input valid, filtered_sample, last_out, output ready);
endinterface

interface smf_cfg_if import smf_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [HALF_BITS-1:0] half_window;

	modport source (output valid, half_window, input ready);
	modport sink   (input valid, half_window, output ready);
endinterface

// ----- rtl/core/sliding_median_filter.sv -----
// sliding median filter top level
//
// Usage: samples come in on a valid/ready channel, one word per signed sample
// with end_of_stream on the final sample of a stream. Results leave on a
// valid/ready channel as filtered_sample with last_out on the final word of
// the stream. half_window (w) is written on its own valid/ready channel,
// which is always ready. The user must write it only while the filter is
// idle; the filter does not enforce this. The first w samples of a stream
// pass through, samples w+1 to 2w yield nothing, later ones emit the median
// of the last 2w+1 samples, and the end of stream flushes the rest, up to w
// samples, oldest first, one word per cycle while the receiver is ready.
// An item that yields nothing leaves the filter idle; a pass-through word
// goes via ST_EMIT to the output register. For a median, the cells rank the
// window by stepping one probe sample per cycle past all of them, then the
// median is picked and loaded via ST_EMIT. Reset clears the sample count and
// sets w to 1. When the receiver stalls, the held word stays put, and input
// is taken again once the last pending word waits in the output register.
`timescale 1ns / 1ps

module sliding_median_filter import smf_pkg::*; #(
	parameter int MAX_HALF    = MAX_HALF_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	smf_in_if.sink        samples,
	smf_out_if.source     results,
	smf_cfg_if.sink       cfg
);

	localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
	localparam int IW        = $clog2(WIN_DEPTH);
	localparam int CW        = $clog2(WIN_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RANK = 4'b0010,
		ST_PICK = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [HALF_BITS-1:0]          hw_q;
	logic [CW-1:0]                 seen_q;
	logic [CW-1:0]                 flush_q;
	logic [IW-1:0]                 j_q;
	logic                          eos_q;
	logic                          first_q;
	logic signed [SAMPLE_BITS-1:0] first_val_q;
	logic                          res_valid_q;
	logic signed [SAMPLE_BITS-1:0] res_data_q;
	logic                          res_last_q;

	logic [CW-1:0]                 w_eff;
	logic [CW-1:0]                 len_w;
	logic [CW-1:0]                 c_w;
	logic [CW-1:0]                 pend_w;
	logic                          raw_hit;
	logic                          med_hit;
	logic                          in_acc;
	logic                          out_free;
	logic                          ld;
	logic signed [SAMPLE_BITS-1:0] ld_data;
	logic                          ld_last;
	logic [IW-1:0]                 rd_idx;
	logic signed [SAMPLE_BITS-1:0] median;
	logic signed [SAMPLE_BITS-1:0] rd_data;
	smf_ctrl_t                     ctrl;

	always_comb begin
		if (32'(hw_q) > 32'(MAX_HALF)) begin
			w_eff = CW'(MAX_HALF);
		end else begin
			w_eff = CW'(hw_q);
		end
	end

	assign len_w   = {w_eff[CW-2:0], 1'b1};
	assign c_w     = (seen_q >= len_w) ? len_w : seen_q + CW'(1);
	assign raw_hit = c_w <= w_eff;
	assign med_hit = c_w == len_w;

	always_comb begin
		if (raw_hit) begin
			pend_w = '0;
		end else if (med_hit) begin
			pend_w = w_eff;
		end else begin
			pend_w = c_w - w_eff;
		end
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_acc        = samples.valid && samples.ready;

	assign ctrl.shift_en = in_acc;
	assign ctrl.rank_clr = in_acc && med_hit;
	assign ctrl.rank_en  = (state_q == ST_RANK);

	assign rd_idx   = IW'(flush_q - CW'(1));
	assign out_free = !res_valid_q || results.ready;

	smf_chain #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_HALF    (MAX_HALF)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample_new (samples.sample_in),
		.probe_idx  (j_q),
		.rd_idx     (rd_idx),
		.w_eff      (w_eff),
		.len_w      (len_w),
		.median     (median),
		.rd_data    (rd_data)
	);

	always_comb begin
		ld      = 1'b0;
		ld_data = first_val_q;
		ld_last = 1'b0;
		if ((state_q == ST_EMIT) && out_free) begin
			if (first_q) begin
				ld      = 1'b1;
				ld_last = eos_q && (flush_q == '0);
			end else if (flush_q != '0) begin
				ld      = 1'b1;
				ld_data = rd_data;
				ld_last = (flush_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			flush_q <= '0;
			j_q     <= '0;
			eos_q   <= 1'b0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						seen_q  <= samples.end_of_stream ? '0 : c_w;
						flush_q <= samples.end_of_stream ? pend_w : '0;
						eos_q   <= samples.end_of_stream;
						first_q <= raw_hit;
						j_q     <= '0;
						if (raw_hit) begin
							state_q <= ST_EMIT;
						end else if (med_hit) begin
							state_q <= ST_RANK;
						end else if (samples.end_of_stream) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_RANK: begin
					j_q <= j_q + IW'(1);
					if (CW'(j_q) == len_w - CW'(1)) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					first_q <= 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (ld) begin
						if (first_q) begin
							first_q <= 1'b0;
							if (flush_q == '0) begin
								state_q <= ST_IDLE;
							end
						end else begin
							flush_q <= flush_q - CW'(1);
							if (flush_q == CW'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			first_val_q <= samples.sample_in;
		end else if (state_q == ST_PICK) begin
			first_val_q <= median;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HALF_RESET;
		end else if (cfg.valid && cfg.ready) begin
			hw_q <= cfg.half_window;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			res_data_q <= ld_data;
			res_last_q <= ld_last;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.filtered_sample = res_data_q;
	assign results.last_out        = res_last_q;

endmodule

// ----- rtl/core/smf_cell.sv -----
// one window cell: holds a sample, shifts it on, and counts its rank
`timescale 1ns / 1ps

module smf_cell import smf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int IW          = 4,
	parameter int IDX         = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smf_ctrl_t                     ctrl,
	input  logic                          active,
	input  logic signed [SAMPLE_BITS-1:0] sample_d,
	input  logic signed [SAMPLE_BITS-1:0] probe,
	input  logic        [IW-1:0]          probe_idx,
	output logic signed [SAMPLE_BITS-1:0] sample_q,
	output logic        [IW-1:0]          rank_q
);

	logic less;

	// ties broken by position so that ranks are unique
	assign less = (probe < sample_q) || ((probe == sample_q) && (probe_idx < IW'(IDX)));

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			sample_q <= sample_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (ctrl.rank_clr) begin
			rank_q <= '0;
		end else if (ctrl.rank_en && active && less) begin
			rank_q <= rank_q + IW'(1);
		end
	end

endmodule

// ----- rtl/core/smf_chain.sv -----
// row of window cells with probe, flush read and median select
`timescale 1ns / 1ps

module smf_chain import smf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_HALF    = MAX_HALF_DEF,
	localparam int WIN_DEPTH  = 2 * MAX_HALF + 1,
	localparam int IW         = $clog2(WIN_DEPTH),
	localparam int CW         = $clog2(WIN_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smf_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample_new,
	input  logic        [IW-1:0]          probe_idx,
	input  logic        [IW-1:0]          rd_idx,
	input  logic        [CW-1:0]          w_eff,
	input  logic        [CW-1:0]          len_w,
	output logic signed [SAMPLE_BITS-1:0] median,
	output logic signed [SAMPLE_BITS-1:0] rd_data
);

	logic signed [SAMPLE_BITS-1:0] smp [WIN_DEPTH];
	logic signed [SAMPLE_BITS-1:0] src [WIN_DEPTH];
	logic        [IW-1:0]          rank [WIN_DEPTH];
	logic        [WIN_DEPTH-1:0]   act;
	logic        [WIN_DEPTH-1:0]   hit;
	logic signed [SAMPLE_BITS-1:0] probe;

	assign probe   = smp[probe_idx];
	assign rd_data = smp[rd_idx];

	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign src[i] = sample_new;
		end else begin : g_link
			assign src[i] = smp[i-1];
		end

		assign act[i] = CW'(i) < len_w;
		assign hit[i] = act[i] && (CW'(rank[i]) == w_eff);

		smf_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.IW          (IW),
			.IDX         (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.active    (act[i]),
			.sample_d  (src[i]),
			.probe     (probe),
			.probe_idx (probe_idx),
			.sample_q  (smp[i]),
			.rank_q    (rank[i])
		);
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (hit[i]) begin
				median = median | smp[i];
			end
		end
	end

endmodule

// ----- rtl/core/smf_chk.sv -----
// port-level assertions of the sliding median filter and their bind
`timescale 1ns / 1ps

module smf_chk import smf_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_eos,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] out_sample,
	input logic                          out_last
);

	// a waiting result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
		else $error("result word changed while stalled");

	// the end of a stream always yields words, so the input must pause
	a_eos_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_eos |=> !in_ready)
		else $error("input still taken after end of stream");

	// the filter only gets busy because of an accepted word
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input ready dropped without an accepted word");

endmodule

bind sliding_median_filter smf_chk #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_smf_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.in_eos     (samples.end_of_stream),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_sample (results.filtered_sample),
	.out_last   (results.last_out)
);
